>>> hdl/dppi_pkg.sv
`timescale 1ns / 1ps

package dppi_pkg;

    // field and state widths
    localparam int GAIN_W  = 24;
    localparam int ACC_W   = 24;
    localparam int FRAC_W  = 16;
    localparam int FLOW_W  = 16;
    localparam int TEMP_W  = 12;
    localparam int CERR_W  = FLOW_W + 1;
    localparam int HERR_W  = TEMP_W + 1;
    localparam int DUTY_W  = ACC_W - FRAC_W;
    localparam int DCNT_W  = 2;
    localparam int DWELL_W = 8;

    // accumulator ceiling: 255.0 in Q.16
    localparam logic [ACC_W-1:0] ACC_MAX = 24'hFF0000;

    // parameter defaults
    localparam int DEF_TEMP_DECIMATION = 3;
    localparam int DEF_TOLERANCE       = 8;
    localparam int DEF_DWELL_TICKS     = 120;

    // register map, word index
    localparam logic [2:0] REG_HEATER_GAIN_NOW    = 3'd0;
    localparam logic [2:0] REG_HEATER_GAIN_PREV   = 3'd1;
    localparam logic [2:0] REG_COOLER_GAIN_NOW    = 3'd2;
    localparam logic [2:0] REG_COOLER_GAIN_PREV   = 3'd3;
    localparam logic [2:0] REG_TEMP_TARGET_FIRST  = 3'd4;
    localparam logic [2:0] REG_TEMP_TARGET_SECOND = 3'd5;
    localparam logic [2:0] REG_FLOW_TARGET_FIRST  = 3'd6;
    localparam logic [2:0] REG_FLOW_TARGET_SECOND = 3'd7;

    // register reset values
    localparam logic [GAIN_W-1:0] RST_HEATER_GAIN_NOW  = 24'd17191;
    localparam logic [GAIN_W-1:0] RST_HEATER_GAIN_PREV = 24'hFFBD2F;  // -17105
    localparam logic [GAIN_W-1:0] RST_COOLER_GAIN_NOW  = 24'd112722;
    localparam logic [GAIN_W-1:0] RST_COOLER_GAIN_PREV = 24'hFEA344;  // -89276
    localparam logic [TEMP_W-1:0] RST_TEMP_TARGET_FIRST  = 12'd640;
    localparam logic [TEMP_W-1:0] RST_TEMP_TARGET_SECOND = 12'd480;
    localparam logic [FLOW_W-1:0] RST_FLOW_TARGET_FIRST  = 16'd0;
    localparam logic [FLOW_W-1:0] RST_FLOW_TARGET_SECOND = 16'd28;

    // per-item status carried down the pipe
    typedef struct packed {
        logic ran;
        logic stage;
        logic dwelling;
    } sched_t;

endpackage

>>> hdl/dppi_sched.sv
`timescale 1ns / 1ps

module dppi_sched #(
    parameter int TEMP_DECIMATION = dppi_pkg::DEF_TEMP_DECIMATION,
    parameter int TOLERANCE       = dppi_pkg::DEF_TOLERANCE,
    parameter int DWELL_TICKS     = dppi_pkg::DEF_DWELL_TICKS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic        [dppi_pkg::FLOW_W-1:0]   flow,
    input  logic        [dppi_pkg::TEMP_W-1:0]   temp,
    input  logic        [dppi_pkg::FLOW_W-1:0]   flow_target_first,
    input  logic        [dppi_pkg::FLOW_W-1:0]   flow_target_second,
    input  logic        [dppi_pkg::TEMP_W-1:0]   temp_target_first,
    input  logic        [dppi_pkg::TEMP_W-1:0]   temp_target_second,
    output logic signed [dppi_pkg::CERR_W-1:0]   cooler_err,
    output logic signed [dppi_pkg::CERR_W-1:0]   cooler_err_last,
    output logic signed [dppi_pkg::HERR_W-1:0]   heater_err,
    output logic signed [dppi_pkg::HERR_W-1:0]   heater_err_last,
    output dppi_pkg::sched_t                     info
);
    import dppi_pkg::*;

    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next, dcnt_inc;
    logic               dwell_reg, dwell_next;
    logic [DWELL_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic               stage_reg, stage_next;
    logic [CERR_W-1:0]  cerr_last_reg;
    logic [HERR_W-1:0]  herr_last_reg, herr_last_next;
    logic [FLOW_W-1:0]  ftgt;
    logic [TEMP_W-1:0]  ttgt;
    logic [HERR_W-1:0]  herr_abs;
    logic               run;

    // setpoints of the stage in force at the start of the tick
    assign ftgt = stage_reg ? flow_target_second : flow_target_first;
    assign ttgt = stage_reg ? temp_target_second : temp_target_first;

    assign cooler_err = {1'b0, ftgt} - {1'b0, flow};
    assign heater_err = {ttgt[TEMP_W-1], ttgt} - {temp[TEMP_W-1], temp};
    assign herr_abs   = heater_err[HERR_W-1] ? (HERR_W'(0) - heater_err) : heater_err;

    assign cooler_err_last = cerr_last_reg;
    assign heater_err_last = herr_last_reg;

    assign dcnt_inc  = dcnt_reg + 1'b1;
    assign run       = (dcnt_inc >= DCNT_W'(TEMP_DECIMATION));
    assign ticks_inc = (dwell_reg && (ticks_reg != {DWELL_W{1'b1}})) ? ticks_reg + 1'b1
                                                                     : ticks_reg;

    always_comb
    begin
        dcnt_next      = run ? '0 : dcnt_inc;
        dwell_next     = dwell_reg;
        ticks_next     = ticks_inc;
        stage_next     = stage_reg;
        herr_last_next = herr_last_reg;
        if (run)
        begin
            herr_last_next = heater_err;
            if (!dwell_reg && (herr_abs <= HERR_W'(TOLERANCE)))
            begin
                dwell_next = 1'b1;
                ticks_next = '0;
            end
            else if (dwell_reg && (ticks_inc >= DWELL_W'(DWELL_TICKS)))
            begin
                // last stage stays put
                dwell_next = 1'b0;
                stage_next = 1'b1;
            end
        end
    end

    assign info = '{ran: run, stage: stage_next, dwelling: dwell_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg      <= '0;
            dwell_reg     <= 1'b0;
            ticks_reg     <= '0;
            stage_reg     <= 1'b0;
            cerr_last_reg <= '0;
            herr_last_reg <= '0;
        end
        else if (advance)
        begin
            dcnt_reg      <= dcnt_next;
            dwell_reg     <= dwell_next;
            ticks_reg     <= ticks_next;
            stage_reg     <= stage_next;
            cerr_last_reg <= cooler_err;
            herr_last_reg <= herr_last_next;
        end
    end

endmodule

>>> hdl/dppi_pi.sv
`timescale 1ns / 1ps

module dppi_pi #(
    parameter int ERR_W = 17
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 step,
    input  logic signed [ERR_W-1:0]              err,
    input  logic signed [ERR_W-1:0]              err_last,
    input  logic signed [dppi_pkg::GAIN_W-1:0]   gain_now,
    input  logic signed [dppi_pkg::GAIN_W-1:0]   gain_prev,
    output logic        [dppi_pkg::DUTY_W-1:0]   duty
);
    import dppi_pkg::*;

    localparam int PROD_W = GAIN_W + ERR_W;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] prod_now_reg, prod_prev_reg;
    logic signed [PROD_W-1:0] prod_now, prod_prev;
    logic signed [SUM_W-1:0]  sum;
    logic        [ACC_W-1:0]  acc_reg, acc_next;

    assign prod_now  = gain_now * err;
    assign prod_prev = gain_prev * err_last;

    // products registered, accumulate in the next stage
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_now_reg  <= prod_now;
            prod_prev_reg <= prod_prev;
        end
    end

    assign sum = {{(SUM_W-ACC_W){1'b0}}, acc_reg}
               + {{(SUM_W-PROD_W){prod_now_reg[PROD_W-1]}}, prod_now_reg}
               + {{(SUM_W-PROD_W){prod_prev_reg[PROD_W-1]}}, prod_prev_reg};

    always_comb
    begin
        if (sum[SUM_W-1])
            acc_next = '0;
        else if ($unsigned(sum) > SUM_W'(ACC_MAX))
            acc_next = ACC_MAX;
        else
            acc_next = sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (step)
            acc_reg <= acc_next;
    end

    assign duty = acc_reg[ACC_W-1:FRAC_W];

endmodule

>>> hdl/dual_pi_loop_with_setpoint_schedule.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Content
// s_*       in   s_tvalid / s_tready           tick: flow_pulses, temperature_sixteenths
// m_*       out  m_tvalid / m_tready           result: duties, heater_updated, stage, dwelling
// apb       in   psel, penable, pwrite, pready gains and setpoints, word address
//
// Three-stage pipe: input register, schedule + product register, accumulate +
// result register. One item per cycle unless m_tready stalls; an item passes the
// input, product and result registers in order. Each stage holds while the one
// below is full and stalled, so up to three items wait on a held-low m_tready.
// Reset clears the loop state, schedule and registers to their defaults.
module dual_pi_loop_with_setpoint_schedule #(
    parameter int TEMP_DECIMATION = dppi_pkg::DEF_TEMP_DECIMATION,
    parameter int TOLERANCE       = dppi_pkg::DEF_TOLERANCE,
    parameter int DWELL_TICKS     = dppi_pkg::DEF_DWELL_TICKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // flow_pulses[15:0], temperature_sixteenths[27:16], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cooler_duty[7:0], heater_duty[15:8], heater_updated[16],
                                   // stage_now[17], dwelling[18], zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dppi_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0] hg_now_reg, hg_prev_reg, cg_now_reg, cg_prev_reg;
    logic [TEMP_W-1:0] tt_first_reg, tt_second_reg;
    logic [FLOW_W-1:0] ft_first_reg, ft_second_reg;
    logic [2:0]        reg_idx;
    logic              cfg_wr;

    // pipe
    logic              s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [FLOW_W-1:0] s1_flow_reg;
    logic [TEMP_W-1:0] s1_temp_reg;
    sched_t            s2_info_reg, out_info_reg, info;
    logic              s_fire, fire1, fire2, s2_ready, out_ready;

    logic signed [CERR_W-1:0] cerr, cerr_last;
    logic signed [HERR_W-1:0] herr, herr_last;
    logic [DUTY_W-1:0]        cooler_duty, heater_duty;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hg_now_reg    <= RST_HEATER_GAIN_NOW;
            hg_prev_reg   <= RST_HEATER_GAIN_PREV;
            cg_now_reg    <= RST_COOLER_GAIN_NOW;
            cg_prev_reg   <= RST_COOLER_GAIN_PREV;
            tt_first_reg  <= RST_TEMP_TARGET_FIRST;
            tt_second_reg <= RST_TEMP_TARGET_SECOND;
            ft_first_reg  <= RST_FLOW_TARGET_FIRST;
            ft_second_reg <= RST_FLOW_TARGET_SECOND;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_HEATER_GAIN_NOW:    hg_now_reg    <= pwdata[GAIN_W-1:0];
                REG_HEATER_GAIN_PREV:   hg_prev_reg   <= pwdata[GAIN_W-1:0];
                REG_COOLER_GAIN_NOW:    cg_now_reg    <= pwdata[GAIN_W-1:0];
                REG_COOLER_GAIN_PREV:   cg_prev_reg   <= pwdata[GAIN_W-1:0];
                REG_TEMP_TARGET_FIRST:  tt_first_reg  <= pwdata[TEMP_W-1:0];
                REG_TEMP_TARGET_SECOND: tt_second_reg <= pwdata[TEMP_W-1:0];
                REG_FLOW_TARGET_FIRST:  ft_first_reg  <= pwdata[FLOW_W-1:0];
                REG_FLOW_TARGET_SECOND: ft_second_reg <= pwdata[FLOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_HEATER_GAIN_NOW:    prdata = {8'd0, hg_now_reg};
            REG_HEATER_GAIN_PREV:   prdata = {8'd0, hg_prev_reg};
            REG_COOLER_GAIN_NOW:    prdata = {8'd0, cg_now_reg};
            REG_COOLER_GAIN_PREV:   prdata = {8'd0, cg_prev_reg};
            REG_TEMP_TARGET_FIRST:  prdata = {20'd0, tt_first_reg};
            REG_TEMP_TARGET_SECOND: prdata = {20'd0, tt_second_reg};
            REG_FLOW_TARGET_FIRST:  prdata = {16'd0, ft_first_reg};
            REG_FLOW_TARGET_SECOND: prdata = {16'd0, ft_second_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- pipe handshake ----------------
    // each stage moves when the stage below is empty or moving
    assign out_ready = !out_valid_reg || m_tready;
    assign fire2     = s2_valid_reg && out_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign fire1     = s1_valid_reg && s2_ready;
    assign s_tready  = !s1_valid_reg || s2_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s2_info_reg   <= '0;
            out_info_reg  <= '0;
        end
        else
        begin
            if (s_fire)
                s1_valid_reg <= 1'b1;
            else if (fire1)
                s1_valid_reg <= 1'b0;

            if (fire1)
            begin
                s2_valid_reg <= 1'b1;
                s2_info_reg  <= info;
            end
            else if (fire2)
                s2_valid_reg <= 1'b0;

            if (fire2)
            begin
                out_valid_reg <= 1'b1;
                out_info_reg  <= s2_info_reg;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_flow_reg <= s_tdata[FLOW_W-1:0];
            s1_temp_reg <= s_tdata[FLOW_W+TEMP_W-1:FLOW_W];
        end
    end

    // ---------------- datapath ----------------
    // schedule: decimation, dwell, stage; errors for both loops
    dppi_sched #(
        .TEMP_DECIMATION (TEMP_DECIMATION),
        .TOLERANCE       (TOLERANCE),
        .DWELL_TICKS     (DWELL_TICKS)
    ) u_sched (
        .clk                (clk),
        .rst_n              (rst_n),
        .advance            (fire1),
        .flow               (s1_flow_reg),
        .temp               (s1_temp_reg),
        .flow_target_first  (ft_first_reg),
        .flow_target_second (ft_second_reg),
        .temp_target_first  (tt_first_reg),
        .temp_target_second (tt_second_reg),
        .cooler_err         (cerr),
        .cooler_err_last    (cerr_last),
        .heater_err         (herr),
        .heater_err_last    (herr_last),
        .info               (info)
    );

    // flow loop runs every tick
    dppi_pi #(
        .ERR_W (CERR_W)
    ) u_cooler (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire1),
        .step      (fire2),
        .err       (cerr),
        .err_last  (cerr_last),
        .gain_now  ($signed(cg_now_reg)),
        .gain_prev ($signed(cg_prev_reg)),
        .duty      (cooler_duty)
    );

    // temperature loop runs on decimated ticks only
    dppi_pi #(
        .ERR_W (HERR_W)
    ) u_heater (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire1),
        .step      (fire2 && s2_info_reg.ran),
        .err       (herr),
        .err_last  (herr_last),
        .gain_now  ($signed(hg_now_reg)),
        .gain_prev ($signed(hg_prev_reg)),
        .duty      (heater_duty)
    );

    // accumulators change only as an item enters the result register,
    // so they always match the item held there
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {13'd0, out_info_reg.dwelling, out_info_reg.stage, out_info_reg.ran,
                       heater_duty, cooler_duty};

    // ---------------- checks ----------------
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> s1_valid_reg)
        else $error("accepted item not held in input stage");

    a_stage_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_info_reg.stage) |-> out_info_reg.stage)
        else $error("setpoint stage went back");

    a_sched_on_temp_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire2 && ((s2_info_reg.stage != out_info_reg.stage) ||
                  (s2_info_reg.dwelling != out_info_reg.dwelling)) |-> s2_info_reg.ran)
        else $error("stage or dwell changed on a flow-only tick");

endmodule
